// File: design/sp2c_pkg.sv
package sp2c_pkg;

  // field widths
  localparam int RANGE_W = 20;
  localparam int INDEX_W = 12;
  localparam int ANGLE_W = 16;
  localparam int POINT_W = 21;

  // datapath widths: x/y carry range << 12 plus cordic growth, z is 2^32 units per turn
  localparam int PRE_SHIFT = 12;
  localparam int XW        = 35;
  localparam int ZW        = 34;
  localparam int ANG_SHIFT = 16;
  localparam int FOLD_W    = ANGLE_W + 1;

  // gain compensation, 0.6072529350 in Q.30
  localparam int GAIN_W            = 30;
  localparam logic [GAIN_W-1:0] GAIN = 30'd652032874;
  localparam int LOW_W             = 17;
  localparam int HI_W              = XW - LOW_W;
  localparam int PL_W              = LOW_W + GAIN_W;
  localparam int PH_W              = HI_W + GAIN_W + 1;
  localparam int SUM_W             = XW + GAIN_W + 1;
  localparam int DROP              = 42;
  localparam int RND_W             = SUM_W - DROP;

  localparam int MAX_STAGES = 24;
  localparam int ATAN_W     = 30;

  // arctangent of 2^-i in 2^-32 turn units
  localparam logic [ATAN_W-1:0] ATAN [MAX_STAGES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ANGLE = 4'd0,
    CFG_ANGLE_STEP  = 4'd1
  } cfg_idx_e;

  // control that travels with each beam down the pipeline
  typedef struct packed {
    logic valid;
    logic neg;
    logic last;
  } ctl_t;

endpackage

// File: design/scan_polar_to_cartesian_core.sv
// path from input transaction to output tvalid: 2 angle stages, one register per
// cordic stage, 3 gain stages, then the output buffer
// throughput: one beam per cycle, set by the fully pipelined cordic and gain multiply
// the pipeline freezes only while the two-entry output buffer is full
// reset: rst_ni asynchronous active low, clears valid bits, buffer state and both
// configuration registers
module scan_polar_to_cartesian_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // beam input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // beam_range[19:0], beam_index[31:20]
  input  logic        s_axis_tlast,   // scan_end
  // point output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // point_x[20:0], point_y[41:21], zero[47:42]
  output logic        m_axis_tlast,   // point_last
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sp2c_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int BUF_W = 2 * sp2c_pkg::POINT_W + 1;

  // configuration registers, always ready
  logic [sp2c_pkg::ANGLE_W-1:0] start_q, step_q;
  logic                         cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      step_q  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        sp2c_pkg::CFG_START_ANGLE: start_q <= cfg_data_i;
        sp2c_pkg::CFG_ANGLE_STEP:  step_q  <= cfg_data_i;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // pipeline advance: global enable while the output buffer has room
  logic [1:0] cnt_q, cnt_d;
  logic       en;

  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // angle generation and fold
  sp2c_pkg::ctl_t                 a_ctl;
  logic signed [sp2c_pkg::XW-1:0] a_x;
  logic signed [sp2c_pkg::ZW-1:0] a_z;

  sp2c_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .range_i (s_axis_tdata[sp2c_pkg::RANGE_W-1:0]),
    .index_i (s_axis_tdata[sp2c_pkg::RANGE_W +: sp2c_pkg::INDEX_W]),
    .last_i  (s_axis_tlast),
    .start_i (start_q),
    .step_i  (step_q),
    .ctl_o   (a_ctl),
    .x_o     (a_x),
    .z_o     (a_z)
  );

  // rotation, one register per micro-rotation
  sp2c_pkg::ctl_t                 r_ctl;
  logic signed [sp2c_pkg::XW-1:0] r_x, r_y;

  sp2c_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (a_ctl),
    .x_i    (a_x),
    .z_i    (a_z),
    .ctl_o  (r_ctl),
    .x_o    (r_x),
    .y_o    (r_y)
  );

  // gain compensation, rounding, saturation
  sp2c_pkg::ctl_t                      g_ctl;
  logic signed [sp2c_pkg::POINT_W-1:0] g_x, g_y;

  sp2c_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (r_ctl),
    .x_i    (r_x),
    .y_i    (r_y),
    .ctl_o  (g_ctl),
    .x_o    (g_x),
    .y_o    (g_y)
  );

  // two-entry output buffer decouples the stall from the pipeline
  logic [BUF_W-1:0] buf_q [2];
  logic             wr_q, rd_q;
  logic             push, pop;

  assign push = en & g_ctl.valid;
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= {g_ctl.last, g_y, g_x};
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {6'b0, buf_q[rd_q][2*sp2c_pkg::POINT_W-1:0]};
  assign m_axis_tlast  = buf_q[rd_q][BUF_W-1];

endmodule

// File: design/sp2c_angle.sv
module sp2c_angle (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [sp2c_pkg::RANGE_W-1:0]           range_i,
  input  logic [sp2c_pkg::INDEX_W-1:0]           index_i,
  input  logic                                   last_i,
  input  logic [sp2c_pkg::ANGLE_W-1:0]           start_i,
  input  logic [sp2c_pkg::ANGLE_W-1:0]           step_i,
  output sp2c_pkg::ctl_t                         ctl_o,
  output logic signed [sp2c_pkg::XW-1:0]         x_o,
  output logic signed [sp2c_pkg::ZW-1:0]         z_o
);

  localparam int PROD_W = sp2c_pkg::INDEX_W + sp2c_pkg::ANGLE_W;
  localparam logic signed [sp2c_pkg::FOLD_W-1:0] QUARTER = 17'sd16384;
  localparam logic signed [sp2c_pkg::FOLD_W-1:0] HALF    = 17'sd32768;

  // stage 1: beam angle
  logic                          v1_q;
  logic                          l1_q;
  logic [sp2c_pkg::ANGLE_W-1:0]  a1_q, a1_d;
  logic [sp2c_pkg::RANGE_W-1:0]  r1_q;
  logic [PROD_W-1:0]             prod;

  assign prod = index_i * step_i;
  assign a1_d = start_i + prod[sp2c_pkg::ANGLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a1_d;
      r1_q <= range_i;
      l1_q <= last_i;
    end
  end

  // stage 2: fold into +-quarter turn, set up the vector
  logic signed [sp2c_pkg::FOLD_W-1:0] s_raw, s_fold;
  logic                               neg_d;
  sp2c_pkg::ctl_t                     ctl_q;
  logic signed [sp2c_pkg::XW-1:0]     x_q, x_d;
  logic signed [sp2c_pkg::ZW-1:0]     z_q, z_d;

  always_comb begin
    s_raw  = {a1_q[sp2c_pkg::ANGLE_W-1], a1_q};
    s_fold = s_raw;
    neg_d  = 1'b0;
    if (s_raw > QUARTER) begin
      s_fold = s_raw - HALF;
      neg_d  = 1'b1;
    end else if (s_raw < -QUARTER) begin
      s_fold = s_raw + HALF;
      neg_d  = 1'b1;
    end
    z_d = sp2c_pkg::ZW'(s_fold) <<< sp2c_pkg::ANG_SHIFT;
    x_d = sp2c_pkg::XW'({r1_q, {sp2c_pkg::PRE_SHIFT{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= v1_q;
      ctl_q.neg   <= neg_d;
      ctl_q.last  <= l1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q        <= x_d;
      z_q        <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign z_o   = z_q;

endmodule

// File: design/sp2c_cordic.sv
module sp2c_cordic #(
  parameter int STAGES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  sp2c_pkg::ctl_t                  ctl_i,
  input  logic signed [sp2c_pkg::XW-1:0]  x_i,
  input  logic signed [sp2c_pkg::ZW-1:0]  z_i,
  output sp2c_pkg::ctl_t                  ctl_o,
  output logic signed [sp2c_pkg::XW-1:0]  x_o,
  output logic signed [sp2c_pkg::XW-1:0]  y_o
);

  sp2c_pkg::ctl_t                 ctl_q [STAGES];
  logic signed [sp2c_pkg::XW-1:0] x_q   [STAGES];
  logic signed [sp2c_pkg::XW-1:0] y_q   [STAGES];
  logic signed [sp2c_pkg::ZW-1:0] z_q   [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    sp2c_pkg::ctl_t                 c_in;
    logic signed [sp2c_pkg::XW-1:0] x_in, y_in, dx, dy, x_d, y_d;
    logic signed [sp2c_pkg::ZW-1:0] z_in, z_d, at;

    if (i == 0) begin : g_first
      assign c_in = ctl_i;
      assign x_in = x_i;
      assign y_in = '0;
      assign z_in = z_i;
    end else begin : g_next
      assign c_in = ctl_q[i-1];
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
    end

    assign at = sp2c_pkg::ZW'(sp2c_pkg::ATAN[i]);

    always_comb begin
      dx = y_in >>> i;
      dy = x_in >>> i;
      // rotate toward zero residual angle
      if (!z_in[sp2c_pkg::ZW-1]) begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - at;
      end else begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[i] <= '0;
      end else if (en_i) begin
        ctl_q[i] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]        <= x_d;
        y_q[i]        <= y_d;
        z_q[i]        <= z_d;
      end
    end
  end

  assign ctl_o = ctl_q[STAGES-1];
  assign x_o   = x_q[STAGES-1];
  assign y_o   = y_q[STAGES-1];

endmodule

// File: design/sp2c_gain.sv
module sp2c_gain (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  sp2c_pkg::ctl_t                      ctl_i,
  input  logic signed [sp2c_pkg::XW-1:0]      x_i,
  input  logic signed [sp2c_pkg::XW-1:0]      y_i,
  output sp2c_pkg::ctl_t                      ctl_o,
  output logic signed [sp2c_pkg::POINT_W-1:0] x_o,
  output logic signed [sp2c_pkg::POINT_W-1:0] y_o
);

  localparam int NEG_W = sp2c_pkg::RND_W + 1;
  localparam logic signed [NEG_W-1:0] OUT_MAX = 25'sd1048575;
  localparam logic signed [NEG_W-1:0] OUT_MIN = -25'sd1048576;
  localparam logic [sp2c_pkg::SUM_W-1:0] ROUND = sp2c_pkg::SUM_W'(1) << (sp2c_pkg::DROP - 1);
  localparam logic signed [sp2c_pkg::POINT_W-1:0] SAT_HI = 21'sd1048575;
  localparam logic signed [sp2c_pkg::POINT_W-1:0] SAT_LO = -21'sd1048576;

  sp2c_pkg::ctl_t c1_q, c2_q, c3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
    end
  end

  logic signed [sp2c_pkg::XW-1:0]      comp_in [2];
  logic signed [sp2c_pkg::POINT_W-1:0] comp_out [2];

  assign comp_in[0] = x_i;
  assign comp_in[1] = y_i;

  for (genvar c = 0; c < 2; c++) begin : g_comp
    logic [sp2c_pkg::LOW_W-1:0]         lo;
    logic signed [sp2c_pkg::HI_W-1:0]   hi;
    logic [sp2c_pkg::PL_W-1:0]          pl_q, pl_d;
    logic signed [sp2c_pkg::PH_W-1:0]   ph_q, ph_d;
    logic signed [sp2c_pkg::SUM_W-1:0]  sum;
    logic signed [sp2c_pkg::RND_W-1:0]  rnd_q, rnd_d;
    logic signed [NEG_W-1:0]            sn;
    logic signed [sp2c_pkg::POINT_W-1:0] sat_q, sat_d;

    // stage 1: two partial products of the gain multiply
    assign lo   = comp_in[c][sp2c_pkg::LOW_W-1:0];
    assign hi   = comp_in[c][sp2c_pkg::XW-1:sp2c_pkg::LOW_W];
    assign pl_d = lo * sp2c_pkg::GAIN;
    assign ph_d = hi * $signed({1'b0, sp2c_pkg::GAIN});

    // stage 2: combine, round half up, drop fraction
    assign sum   = (sp2c_pkg::SUM_W'(ph_q) <<< sp2c_pkg::LOW_W)
                   + sp2c_pkg::SUM_W'(pl_q) + ROUND;
    assign rnd_d = sum[sp2c_pkg::SUM_W-1:sp2c_pkg::DROP];

    // stage 3: undo the fold, saturate
    always_comb begin
      sn = c2_q.neg ? -NEG_W'(rnd_q) : NEG_W'(rnd_q);
      if (sn > OUT_MAX) begin
        sat_d = SAT_HI;
      end else if (sn < OUT_MIN) begin
        sat_d = SAT_LO;
      end else begin
        sat_d = sn[sp2c_pkg::POINT_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pl_q  <= pl_d;
        ph_q  <= ph_d;
        rnd_q <= rnd_d;
        sat_q <= sat_d;
      end
    end

    assign comp_out[c] = sat_q;
  end

  assign ctl_o = c3_q;
  assign x_o   = comp_out[0];
  assign y_o   = comp_out[1];

endmodule

// File: design/sp2c_checker.sv
module sp2c_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  localparam int DEPTH = CORDIC_STAGES + 7;
  localparam int CW    = $clog2(DEPTH + 2);

  // beams accepted but not yet delivered
  logic [CW-1:0] out_q, out_d;
  logic          in_hs, out_hs;

  assign in_hs  = s_axis_tvalid & s_axis_tready;
  assign out_hs = m_axis_tvalid & m_axis_tready;

  always_comb begin
    out_d = out_q;
    if (in_hs && !out_hs) begin
      out_d = out_q + CW'(1);
    end else if (out_hs && !in_hs) begin
      out_d = out_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else begin
      out_q <= out_d;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled point changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_q != '0)
    else $error("point without a pending beam");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q <= CW'(DEPTH))
    else $error("more beams in flight than pipeline holds");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no point waiting");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:42] == 6'b0)
    else $error("tdata padding not zero");

endmodule

bind scan_polar_to_cartesian_core sp2c_checker #(
  .CORDIC_STAGES (CORDIC_STAGES)
) u_sp2c_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES  = 16;
  // used to size the wait before the final check
  localparam int LATENCY = STAGES + 5;

  // a register index that the core does not decode, written once to check it is ignored
  localparam logic [sp2c_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd7;

  // cordic gain compensation in Q.30 and the rounding drop
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam int     RND_DROP  = 42;
  localparam longint POINT_MAX = 64'sd1048575;
  localparam longint POINT_MIN = -64'sd1048576;

  // arctangent of 2^-i, in 2^-32 turn units
  localparam longint TURN_ATAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic [19:0] dist_mm;
    logic [11:0] index;
    logic        last;
  } beam_t;

  typedef struct {
    logic [20:0] px;
    logic [20:0] py;
    logic        plast;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [sp2c_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // local copy of the angle registers, updated at each accepted config transaction to a decoded index
  logic [15:0] cfg_start = '0;
  logic [15:0] cfg_step  = '0;

  beam_t  beams_pending [$];
  point_t points_due [$];
  beam_t  beam_now;
  int     mismatches = 0;

  // sender and receiver idling state
  int tx_gap, tx_calm, rx_gap, rx_calm;

  scan_polar_to_cartesian_core #(
    .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // gain compensation, round half up, optional negation from the fold, then clamp
  function automatic logic [20:0] scale_component(longint v, bit flip);
    longint r;
    r = (v * GAIN_Q30 + (64'sd1 <<< (RND_DROP - 1))) >>> RND_DROP;
    if (flip) r = -r;
    if (r > POINT_MAX) r = POINT_MAX;
    if (r < POINT_MIN) r = POINT_MIN;
    return r[20:0];
  endfunction

  // beam angle from the registers, fold into +-quarter turn, rotate (range, 0)
  function automatic point_t convert_beam(beam_t b);
    logic [15:0] ang;
    int          folded;
    bit          flip;
    longint      cx, cy, cz, dx, dy;
    point_t      p;
    ang    = cfg_start + b.index * cfg_step;
    folded = int'($signed(ang));
    flip   = 1'b0;
    if (folded > 16384) begin
      folded -= 32768;
      flip = 1'b1;
    end else if (folded < -16384) begin
      folded += 32768;
      flip = 1'b1;
    end
    cx = longint'(b.dist_mm) <<< 12;
    cy = 0;
    cz = longint'(folded) * 65536;
    for (int i = 0; i < STAGES; i++) begin
      // arithmetic shift on a signed value is the floor shift
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx;
        cy += dy;
        cz -= TURN_ATAN[i];
      end else begin
        cx += dx;
        cy -= dy;
        cz += TURN_ATAN[i];
      end
    end
    p.px    = scale_component(cx, flip);
    p.py    = scale_component(cy, flip);
    p.plast = b.last;
    return p;
  endfunction

  // idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // beam driver: predicts on each accepted input transaction, then presents the next beam
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      tx_gap  = 0;
      tx_calm = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) points_due.insert(points_due.size(), convert_beam(beam_now));
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (beams_pending.size() != 0) begin
        beam_now = beams_pending.pop_front();
        s_axis_tdata  <= {beam_now.index, beam_now.dist_mm};
        s_axis_tlast  <= beam_now.last;
        s_axis_tvalid <= 1'b1;
        // calm stretches send back to back, otherwise a gap now and then
        if (tx_calm > 0) tx_calm--;
        else if ($urandom_range(0, 99) < 2) tx_calm = $urandom_range(30, 150);
        else if ($urandom_range(0, 3) == 0) tx_gap = idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, point_t want, point_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b", $realtime,
               what, $signed(want.px), $signed(want.py), want.plast,
               $signed(got.px), $signed(got.py), got.plast);
  endtask

  // point monitor: checks each output transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    point_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap  = 0;
      rx_calm = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.px    = m_axis_tdata[20:0];
        got.py    = m_axis_tdata[41:21];
        got.plast = m_axis_tlast;
        if (points_due.size() == 0) begin
          want = '{default: '0};
          report_mismatch("point with none outstanding", want, got);
        end else begin
          want = points_due.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.plast !== want.plast)
            report_mismatch("point mismatch", want, got);
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (rx_calm > 0) begin
        rx_calm--;
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        rx_calm = $urandom_range(30, 150);
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_gap = idle_len() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one config transaction; the local copy follows only the decoded indexes
  task automatic write_reg(logic [sp2c_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == sp2c_pkg::CFG_START_ANGLE) cfg_start = val;
    else if (idx == sp2c_pkg::CFG_ANGLE_STEP) cfg_step = val;
  endtask

  task automatic set_angles(logic [15:0] start, logic [15:0] step);
    write_reg(sp2c_pkg::CFG_START_ANGLE, start);
    write_reg(sp2c_pkg::CFG_ANGLE_STEP, step);
  endtask

  task automatic add_beam(int unsigned dist_mm, int unsigned index, bit last);
    beam_t b;
    b.dist_mm = dist_mm[19:0];
    b.index   = index[11:0];
    b.last    = last;
    beams_pending.insert(beams_pending.size(), b);
  endtask

  // block until nothing is queued, in flight or outstanding; sampled mid-cycle
  // so that the clocked driver and monitor have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (beams_pending.size() != 0 || s_axis_tvalid || points_due.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic int unsigned random_range_value();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1048575;
      2:       return $urandom_range(0, 31);
      3:       return $urandom_range(1048000, 1048575);
      default: return $urandom_range(0, 1048575);
    endcase
  endfunction

  // mostly whole scans with consecutive indexes and the end mark on the last beam,
  // the rest single beams with random index and mark
  task automatic queue_random_beams(int n);
    int left, len, first;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(1, 48);
        if (len > left) len = left;
        first = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4096 - len);
        for (int k = 0; k < len; k++)
          add_beam(random_range_value(), first + k, k == len - 1);
      end else begin
        len = 1;
        add_beam(random_range_value(), $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
      end
      left -= len;
    end
  endtask

  initial begin
    logic [15:0] starts [7];
    logic [15:0] steps [7];
    starts = '{16'd0, 16'd65535, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0};
    steps  = '{16'd0, 16'd65535, 16'd1, 16'd7, 16'd0, 16'd0, 16'd0};
    for (int k = 4; k < 7; k++) begin
      starts[k] = 16'($urandom_range(0, 65535));
      steps[k]  = 16'($urandom_range(0, 65535));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset angles: every beam points along x, zero and full range, index extremes
    add_beam(0, 0, 0);
    add_beam(1048575, 0, 0);
    add_beam(1048575, 4095, 1);
    add_beam(1, 2048, 0);
    add_beam(524288, 1, 1);
    wait_drained();

    // step 16 puts indexes on the quarter and half turn fold boundaries
    set_angles(16'd0, 16'd16);
    add_beam(1048575, 1023, 0);
    add_beam(1048575, 1024, 0);
    add_beam(1048575, 1025, 0);
    add_beam(1048575, 2048, 0);
    add_beam(1048575, 3071, 0);
    add_beam(1048575, 3072, 0);
    add_beam(1048575, 3073, 0);
    add_beam(1048575, 4095, 1);
    add_beam(0, 1024, 0);
    add_beam(1, 2048, 0);
    add_beam(1000, 512, 1);
    wait_drained();

    // register extremes, angle wraps for every nonzero index; an undecoded index is ignored
    set_angles(16'hFFFF, 16'hFFFF);
    write_reg(CFG_UNUSED_IDX, 16'hA5A5);
    add_beam(1048575, 0, 0);
    add_beam(1048575, 1, 0);
    add_beam(1048575, 2047, 0);
    add_beam(1048575, 2048, 0);
    add_beam(1048575, 4095, 1);
    wait_drained();

    // random phases, one per angle setting
    for (int p = 0; p < 7; p++) begin
      set_angles(starts[p], steps[p]);
      if (p == 0) begin
        // sender holds off mid-phase until every point has come back
        queue_random_beams(117);
        wait_drained();
        queue_random_beams(118);
      end else begin
        queue_random_beams(235);
      end
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && points_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
